### design/orbw_pkg.sv
// Package for the overwrite ring buffer core: field widths, opcodes, the command
// and status structs between the controller and the datapath, and the result struct.
// Depends on nothing.
`default_nettype none

package orbw_pkg;

  localparam int unsigned DATA_W       = 16;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned CAPACITY_DEF = 64;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

  typedef struct packed {
    logic do_push;
    logic do_clear;
    logic do_status;
    logic rd_start;
    logic rd_emit;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
    logic n_zero;
    logic last_sample;
  } status_t;

  typedef struct packed {
    logic                     has_sample;
    logic signed [DATA_W-1:0] out_x1;
    logic signed [DATA_W-1:0] out_x2;
    logic signed [DATA_W-1:0] out_sum;
    logic [CNT_W-1:0]         copied_total;
    logic [CNT_W-1:0]         fill_level;
    logic                     last;
  } result_t;

endpackage

`default_nettype wire

### design/orbw_if.sv
// Channel interfaces of the ring buffer core: the command channel and the
// result channel, each with valid, ready and payload. Depends on orbw_pkg.
`default_nettype none

interface orbw_in_if;
  logic                                      valid;
  logic                                      ready;
  logic [orbw_pkg::OP_W-1:0]                 opcode;
  logic signed [orbw_pkg::DATA_W-1:0]        in_x1;
  logic signed [orbw_pkg::DATA_W-1:0]        in_x2;
  logic signed [orbw_pkg::DATA_W-1:0]        in_sum;
  logic [orbw_pkg::CNT_W-1:0]                want_count;

  modport source (output valid, opcode, in_x1, in_x2, in_sum, want_count, input ready);
  modport sink (input valid, opcode, in_x1, in_x2, in_sum, want_count, output ready);
endinterface

interface orbw_out_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      has_sample;
  logic signed [orbw_pkg::DATA_W-1:0]        out_x1;
  logic signed [orbw_pkg::DATA_W-1:0]        out_x2;
  logic signed [orbw_pkg::DATA_W-1:0]        out_sum;
  logic [orbw_pkg::CNT_W-1:0]                copied_total;
  logic [orbw_pkg::CNT_W-1:0]                fill_level;
  logic                                      last;

  modport source (output valid, has_sample, out_x1, out_x2, out_sum, copied_total,
                  fill_level, last, input ready);
  modport sink (input valid, has_sample, out_x1, out_x2, out_sum, copied_total,
                fill_level, last, output ready);
endinterface

`default_nettype wire

### design/orbw_ctrl.sv
// Controller of the ring buffer core: decodes each command transaction and
// sequences the emission of a read window. Depends on orbw_pkg.
`default_nettype none

module orbw_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [orbw_pkg::OP_W-1:0] opcode_i,
  input  wire logic                      out_ready_i,
  input  wire orbw_pkg::status_t         status_i,
  output orbw_pkg::cmd_t                 cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_q, state_d;
  logic out_free;
  logic accept;

  assign out_free   = !status_i.out_valid || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (opcode_i)
            orbw_pkg::OP_PUSH: begin
              cmd_o.do_push   = 1'b1;
              cmd_o.do_status = 1'b1;
            end
            orbw_pkg::OP_CLEAR: begin
              cmd_o.do_clear  = 1'b1;
              cmd_o.do_status = 1'b1;
            end
            orbw_pkg::OP_READ: begin
              if (status_i.n_zero) begin
                cmd_o.do_status = 1'b1;
              end else begin
                cmd_o.rd_start = 1'b1;
                state_d        = S_READ;
              end
            end
            default: begin
              cmd_o.do_status = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd_o.rd_emit = 1'b1;
          if (status_i.last_sample) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### design/orbw_dp.sv
// Datapath of the ring buffer core: sample memory, write position, fill
// count, read address walk and the result register. Depends on orbw_pkg.
`default_nettype none

module orbw_dp #(
  parameter int unsigned CAPACITY = orbw_pkg::CAPACITY_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire orbw_pkg::cmd_t                     cmd_i,
  input  wire logic signed [orbw_pkg::DATA_W-1:0] in_x1_i,
  input  wire logic signed [orbw_pkg::DATA_W-1:0] in_x2_i,
  input  wire logic signed [orbw_pkg::DATA_W-1:0] in_sum_i,
  input  wire logic [orbw_pkg::CNT_W-1:0]         want_count_i,
  input  wire logic                               out_ready_i,
  output orbw_pkg::status_t                       status_o,
  output logic                                    out_valid_o,
  output orbw_pkg::result_t                       result_o
);

  localparam int unsigned AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW     = orbw_pkg::CNT_W;
  localparam int unsigned DW     = orbw_pkg::DATA_W;
  localparam int unsigned SW     = 3 * DW;
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

  logic [SW-1:0]     mem [CAPACITY];
  logic [AW-1:0]     wp_q;
  logic [CW-1:0]     fill_q, fill_d;
  logic [SW-1:0]     rd_data_q;
  logic [AW-1:0]     rd_addr_q;
  logic [CW-1:0]     remain_q;
  logic [CW-1:0]     total_q;
  logic              out_valid_q;
  orbw_pkg::result_t result_q;

  logic [CW-1:0]     n_win;
  logic [CW:0]       wp_ext;
  logic [CW:0]       start_ext;
  logic [AW-1:0]     start_a;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              last_sample;

  function automatic logic [AW-1:0] inc_addr(input logic [AW-1:0] a);
    inc_addr = (a == LAST_A) ? '0 : a + AW'(1);
  endfunction

  assign n_win     = (want_count_i < fill_q) ? want_count_i : fill_q;
  assign wp_ext    = (CW + 1)'(wp_q);
  assign start_ext = (wp_ext >= {1'b0, n_win}) ? wp_ext - {1'b0, n_win}
                                               : wp_ext + {1'b0, CAP_C} - {1'b0, n_win};
  assign start_a   = start_ext[AW-1:0];

  assign last_sample = (remain_q == CW'(1));
  assign rd_en       = cmd_i.rd_start || (cmd_i.rd_emit && !last_sample);
  assign rd_addr     = cmd_i.rd_start ? start_a : rd_addr_q;

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.do_clear) begin
      fill_d = '0;
    end else if (cmd_i.do_push && (fill_q != CAP_C)) begin
      fill_d = fill_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_push) begin
      mem[wp_q] <= {in_x1_i, in_x2_i, in_sum_i};
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      fill_q      <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (cmd_i.do_clear) begin
        wp_q <= '0;
      end else if (cmd_i.do_push) begin
        wp_q <= inc_addr(wp_q);
      end
      if (cmd_i.rd_start) begin
        remain_q <= n_win;
      end else if (cmd_i.rd_emit) begin
        remain_q <= remain_q - CW'(1);
      end
      if (cmd_i.do_status || cmd_i.rd_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_start) begin
      total_q <= n_win;
    end
    if (rd_en) begin
      rd_addr_q <= inc_addr(rd_addr);
    end
    if (cmd_i.do_status) begin
      result_q.has_sample   <= 1'b0;
      result_q.out_x1       <= '0;
      result_q.out_x2       <= '0;
      result_q.out_sum      <= '0;
      result_q.copied_total <= '0;
      result_q.fill_level   <= fill_d;
      result_q.last         <= 1'b1;
    end else if (cmd_i.rd_emit) begin
      result_q.has_sample   <= 1'b1;
      result_q.out_x1       <= rd_data_q[SW-1:2*DW];
      result_q.out_x2       <= rd_data_q[2*DW-1:DW];
      result_q.out_sum      <= rd_data_q[DW-1:0];
      result_q.copied_total <= total_q;
      result_q.fill_level   <= fill_q;
      result_q.last         <= last_sample;
    end
  end

  assign status_o.out_valid   = out_valid_q;
  assign status_o.n_zero      = (n_win == '0);
  assign status_o.last_sample = last_sample;
  assign out_valid_o          = out_valid_q;
  assign result_o             = result_q;

endmodule

`default_nettype wire

### design/overwrite_ring_buffer_latest_window_core.sv
// Top level of the overwrite ring buffer core: joins the controller and the
// datapath to the command and result channels. Depends on orbw_pkg, orbw_if,
// orbw_ctrl and orbw_dp.
`default_nettype none

// The core keeps the newest CAPACITY three-channel samples and overwrites the
// oldest one once full. Push, clear and query each give one result transaction
// carrying the fill level after the operation. A read of n gives min(n, fill)
// sample transactions, oldest first, with last on the final one, or a single
// empty transaction when nothing is copied. A read first fetches the oldest
// sample from the registered memory port and then hands out one sample per
// cycle while the result side takes them; no new command is taken until the
// window has been handed out.
module overwrite_ring_buffer_latest_window_core #(
  parameter int unsigned CAPACITY = orbw_pkg::CAPACITY_DEF
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  orbw_in_if.sink  in_ch,
  orbw_out_if.source out_ch
);

  orbw_pkg::cmd_t    cmd;
  orbw_pkg::status_t status;
  orbw_pkg::result_t result;
  logic              out_valid;

  orbw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .opcode_i    (in_ch.opcode),
    .out_ready_i (out_ch.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  orbw_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_x1_i      (in_ch.in_x1),
    .in_x2_i      (in_ch.in_x2),
    .in_sum_i     (in_ch.in_sum),
    .want_count_i (in_ch.want_count),
    .out_ready_i  (out_ch.ready),
    .status_o     (status),
    .out_valid_o  (out_valid),
    .result_o     (result)
  );

  assign out_ch.valid        = out_valid;
  assign out_ch.has_sample   = result.has_sample;
  assign out_ch.out_x1       = result.out_x1;
  assign out_ch.out_x2       = result.out_x2;
  assign out_ch.out_sum      = result.out_sum;
  assign out_ch.copied_total = result.copied_total;
  assign out_ch.fill_level   = result.fill_level;
  assign out_ch.last         = result.last;

endmodule

`default_nettype wire

### dv/orbw_window_checker.sv
// Scoreboard for the overwrite ring buffer core. It predicts the result transactions of
// each accepted command, compares them with the result channel and counts the failures.
// Depends on orbw_pkg and the channel interfaces in orbw_if.
module orbw_window_checker #(
  parameter int unsigned CAPACITY = orbw_pkg::CAPACITY_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  orbw_in_if   in_mon,
  orbw_out_if  out_mon,
  output int   fail_count_o,
  output int   pending_o
);
  import orbw_pkg::*;

  localparam int unsigned SAMPLE_W = 3 * DATA_W;

  logic [SAMPLE_W-1:0] sample_mem [CAPACITY];
  int unsigned         write_slot;
  int unsigned         stored;
  result_t             predicted_q [$];

  function automatic result_t window_result(input logic has, input logic [SAMPLE_W-1:0] s,
                                            input int unsigned total, input logic last);
    result_t r;
    r.has_sample   = has;
    r.out_x1       = s[3*DATA_W-1:2*DATA_W];
    r.out_x2       = s[2*DATA_W-1:DATA_W];
    r.out_sum      = s[DATA_W-1:0];
    r.copied_total = CNT_W'(total);
    r.fill_level   = CNT_W'(stored);
    r.last         = last;
    return r;
  endfunction

  task automatic predict_command(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] s,
                                 input int unsigned want);
    int unsigned n;
    int unsigned first;
    n     = (want < stored) ? want : stored;
    first = (write_slot + CAPACITY - n) % CAPACITY;
    case (op)
      OP_PUSH: begin
        sample_mem[write_slot] = s;
        write_slot = (write_slot + 1) % CAPACITY;
        if (stored < CAPACITY) stored++;
        predicted_q.push_back(window_result(1'b0, '0, 0, 1'b1));
      end
      OP_READ: begin
        if (n == 0) begin
          predicted_q.push_back(window_result(1'b0, '0, 0, 1'b1));
        end else begin
          for (int i = 0; i < n; i++) begin
            predicted_q.push_back(window_result(1'b1, sample_mem[(first + i) % CAPACITY], n,
                                                i + 1 == n));
          end
        end
      end
      OP_CLEAR: begin
        write_slot = 0;
        stored     = 0;
        predicted_q.push_back(window_result(1'b0, '0, 0, 1'b1));
      end
      OP_QUERY: begin
        predicted_q.push_back(window_result(1'b0, '0, 0, 1'b1));
      end
    endcase
  endtask

  task automatic check_field(input string field, input logic [DATA_W-1:0] exp_v, act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  // Handshake signals are stable at the falling edge, so a transaction seen here is the
  // one taken at the next rising edge. Commands go first, since a result can never belong
  // to the command taken at the same edge.
  always @(negedge clk_i) begin : monitor
    result_t exp_r;
    if (!rst_ni) begin
      write_slot   = 0;
      stored       = 0;
      fail_count_o = 0;
      predicted_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        predict_command(in_mon.opcode, {in_mon.in_x1, in_mon.in_x2, in_mon.in_sum},
                        32'(in_mon.want_count));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (predicted_q.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, got x1 %h fill %0d",
                   $time, out_mon.out_x1, out_mon.fill_level);
          fail_count_o++;
        end else begin
          exp_r = predicted_q.pop_front();
          check_field("has_sample", DATA_W'(exp_r.has_sample), DATA_W'(out_mon.has_sample));
          check_field("out_x1", exp_r.out_x1, out_mon.out_x1);
          check_field("out_x2", exp_r.out_x2, out_mon.out_x2);
          check_field("out_sum", exp_r.out_sum, out_mon.out_sum);
          check_field("copied_total", DATA_W'(exp_r.copied_total),
                      DATA_W'(out_mon.copied_total));
          check_field("fill_level", DATA_W'(exp_r.fill_level), DATA_W'(out_mon.fill_level));
          check_field("last", DATA_W'(exp_r.last), DATA_W'(out_mon.last));
        end
      end
    end
    pending_o = predicted_q.size();
  end

endmodule

### dv/tb.sv
// Top of the ring buffer testbench: clock, reset, command stimulus and result-side
// back-pressure, with the verdict taken from the scoreboard's failure count.
// Depends on orbw_pkg, orbw_if, the core and orbw_window_checker.
module tb;
  import orbw_pkg::*;

  localparam int unsigned RING_DEPTH   = CAPACITY_DEF;
  localparam int          RANDOM_ITEMS = 130;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          CYCLE_LIMIT  = 1_000_000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending_results;
  int   cycle_count = 0;
  int   rx_hold     = 0;
  int   rx_cycle    = 0;
  bit   quiet_tx    = 1'b0;

  orbw_in_if  in_ch ();
  orbw_out_if out_ch ();

  overwrite_ring_buffer_latest_window_core #(
    .CAPACITY(RING_DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  orbw_window_checker #(
    .CAPACITY(RING_DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending_results)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic logic [CNT_W-1:0] read_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return CNT_W'($urandom_range(0, 8));
    if (r < 75) return CNT_W'($urandom_range(0, CAPACITY_DEF));
    if (r < 90) return CNT_W'(CAPACITY_DEF);
    return CNT_W'($urandom_range(CAPACITY_DEF + 1, 127));
  endfunction

  // The result side stalls at random, except in a recurring quiet stretch in which no new stall begins.
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_hold > 0) begin
      rx_hold      <= rx_hold - 1;
      out_ch.ready <= 1'b0;
    end else if ((rx_cycle % 600) >= 150 && $urandom_range(0, 99) < 30) begin
      rx_hold      <= idle_cycles();
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Called at a rising edge; returns at the rising edge where the command is taken.
  task automatic send_command(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] x1, x2,
                              sum, input logic [CNT_W-1:0] want);
    int gap;
    bit fire;
    gap = quiet_tx ? 0 : idle_cycles();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.in_x1      <= x1;
    in_ch.in_x2      <= x2;
    in_ch.in_sum     <= sum;
    in_ch.want_count <= want;
    do begin
      @(negedge clk_i);
      fire = in_ch.ready;
      @(posedge clk_i);
    end while (!fire);
  endtask

  initial begin
    logic [OP_W-1:0] op;
    int              r;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_QUERY;
    in_ch.in_x1      = '0;
    in_ch.in_x2      = '0;
    in_ch.in_sum     = '0;
    in_ch.want_count = '0;
    out_ch.ready     = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_command(OP_READ, 16'h1234, 16'h5678, 16'h9abc, 7'd5);
    send_command(OP_QUERY, '0, '0, '0, '0);
    send_command(OP_PUSH, 16'h8000, 16'h7fff, 16'h0000, 7'd0);
    send_command(OP_PUSH, 16'h7fff, 16'h8000, 16'hffff, 7'd127);
    send_command(OP_PUSH, 16'h5555, 16'haaaa, 16'h00ff, 7'd64);
    send_command(OP_READ, '0, '0, '0, 7'd0);
    send_command(OP_READ, '0, '0, '0, 7'd2);
    send_command(OP_READ, '0, '0, '0, 7'd64);
    send_command(OP_READ, 16'hffff, 16'hffff, 16'hffff, 7'd127);
    send_command(OP_QUERY, '0, '0, '0, '0);
    send_command(OP_CLEAR, 16'hffff, 16'hffff, 16'hffff, 7'd127);
    send_command(OP_QUERY, '0, '0, '0, '0);
    send_command(OP_READ, '0, '0, '0, 7'd1);
    send_command(OP_PUSH, 16'hffff, 16'h0000, 16'h0001, 7'd0);
    send_command(OP_READ, '0, '0, '0, 7'd1);
    send_command(OP_CLEAR, '0, '0, '0, '0);

    // The first stretch has no clears, so the store fills up and wraps around.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 25 == 0) quiet_tx = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (i < 90) begin
        op = (r < 85) ? OP_PUSH : (r < 95) ? OP_READ : OP_QUERY;
      end else begin
        op = (r < 50) ? OP_PUSH : (r < 82) ? OP_READ : (r < 92) ? OP_QUERY : OP_CLEAR;
      end
      send_command(op, DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
                   (op == OP_READ) ? read_request() : CNT_W'($urandom));
    end
    in_ch.valid <= 1'b0;

    while (pending_results != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
design/orbw_pkg.sv
design/orbw_if.sv
design/orbw_ctrl.sv
design/orbw_dp.sv
design/overwrite_ring_buffer_latest_window_core.sv
dv/orbw_window_checker.sv
dv/tb.sv
